[rtl/banked_memory_mapper_macros.svh]
// assertion helpers included by the mapper top level
`ifndef BANKED_MEMORY_MAPPER_MACROS_SVH
`define BANKED_MEMORY_MAPPER_MACROS_SVH

// clocked check, masked while reset is asserted
`define BMM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define BMM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bmm_pkg.sv]
`default_nettype none

package bmm_pkg;

	localparam int unsigned AddrW   = 16;
	localparam int unsigned DataW   = 8;
	localparam int unsigned OffW    = 14;
	localparam int unsigned BankW   = 3;
	localparam int unsigned RamLocW = BankW + OffW;
	localparam int unsigned SlotW   = 8;
	localparam int unsigned NumSlot = 1 << SlotW;
	localparam int unsigned ApbDW   = 64;
	localparam int unsigned ApbAW   = 6;

	typedef enum logic [1:0] {
		ACT_MEM_RD = 2'd0,
		ACT_MEM_WR = 2'd1,
		ACT_IO_WR  = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		TGT_NONE = 3'd0,
		TGT_RAM  = 3'd1,
		TGT_LROM = 3'd2,
		TGT_IROM = 3'd3,
		TGT_EXP  = 3'd4
	} target_t;

	typedef enum logic [2:0] {
		REG_RAM128  = 3'd0,
		REG_SLOTS_A = 3'd1,
		REG_SLOTS_B = 3'd2,
		REG_SLOTS_C = 3'd3,
		REG_SLOTS_D = 3'd4
	} reg_idx_t;

	localparam logic [1:0] AREA_LOW  = 2'd0;
	localparam logic [1:0] AREA_HIGH = 2'd3;
	localparam logic [1:0] RAMCFG_SEL = 2'b11;

	typedef struct packed {
		logic               ram_128k_enable;
		logic [NumSlot-1:0] slots_present;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [AddrW-1:0] bus_address;
		logic [DataW-1:0] bus_data;
		logic             lower_rom_on;
		logic             upper_rom_on;
	} item_t;

	typedef struct packed {
		target_t            target;
		logic [RamLocW-1:0] ram_location;
		logic [OffW-1:0]    rom_offset;
		logic [SlotW-1:0]   exp_slot;
		logic               write_strobe;
		logic [DataW-1:0]   write_byte;
	} result_t;

	function automatic logic [BankW-1:0] bank_of(input logic [2:0] cfg, input logic [1:0] area);
		logic [BankW-1:0] bank;
		bank = {1'b0, area};
		unique case (cfg)
			3'd0: bank = {1'b0, area};
			3'd1: bank = (area == AREA_HIGH) ? 3'd7 : {1'b0, area};
			3'd2: bank = {1'b1, area};
			3'd3: begin
				unique case (area)
					2'd0: bank = 3'd0;
					2'd1: bank = 3'd3;
					2'd2: bank = 3'd2;
					2'd3: bank = 3'd7;
					default: bank = 3'd0;
				endcase
			end
			default: bank = (area == 2'd1) ? cfg : {1'b0, area};
		endcase
		return bank;
	endfunction

endpackage

`default_nettype wire

[rtl/banked_memory_mapper.sv]
// channel   | valid/ready          | payload
// ----------+----------------------+-----------------------------------------------
// request   | in_valid / in_ready  | action bus_address bus_data lower/upper_rom_on
// result    | out_valid / out_ready| target ram_location rom_offset exp_slot
//           |                      | write_strobe write_byte
// config    | psel penable pwrite  | paddr pwdata prdata, pready tied high
//
// one request per clock sustained while out_ready is high; a result passes through the input then result register
// bank/slot state is read and updated as a request moves from input to result register
// async reset clears valids, mapping state and slot presence bits, enable bit set
// a stalled result holds; the input register still takes one more request behind it
`default_nettype none
`include "banked_memory_mapper_macros.svh"

module banked_memory_mapper (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [bmm_pkg::ApbAW-1:0] paddr,
	input  wire logic [bmm_pkg::ApbDW-1:0] pwdata,
	output logic      [bmm_pkg::ApbDW-1:0] prdata,
	output logic                           pready,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                action,
	input  wire logic [15:0]               bus_address,
	input  wire logic [7:0]                bus_data,
	input  wire logic                      lower_rom_on,
	input  wire logic                      upper_rom_on,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [2:0]                     target,
	output logic [16:0]                    ram_location,
	output logic [13:0]                    rom_offset,
	output logic [7:0]                     exp_slot,
	output logic                           write_strobe,
	output logic [7:0]                     write_byte
);
	import bmm_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_c;
	result_t res_s2;
	logic    valid_s2;
	logic    adv;

	bmm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bmm_xlate u_xlate (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.step   (adv),
		.res    (res_c)
	);

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action       <= action;
			item_s1.bus_address  <= bus_address;
			item_s1.bus_data     <= bus_data;
			item_s1.lower_rom_on <= lower_rom_on;
			item_s1.upper_rom_on <= upper_rom_on;
		end
		if (adv) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid    = valid_s2;
	assign target       = res_s2.target;
	assign ram_location = res_s2.ram_location;
	assign rom_offset   = res_s2.rom_offset;
	assign exp_slot     = res_s2.exp_slot;
	assign write_strobe = res_s2.write_strobe;
	assign write_byte   = res_s2.write_byte;

	`BMM_ASSERT(a_strobe_ram, out_valid && write_strobe |-> target == TGT_RAM, "strobe off ram")
	`BMM_ASSERT(a_exp_slot, out_valid && target == TGT_EXP |-> exp_slot != 8'd0, "exp slot zero")
	`BMM_ASSERT(a_slot_clear, out_valid && target != TGT_EXP |-> exp_slot == 8'd0, "stray slot")
	`BMM_ASSERT_ALWAYS(a_no_drop, valid_s1 && !in_ready |-> valid_s2 && !out_ready, "stall leak")

endmodule

`default_nettype wire

[rtl/bmm_cfg.sv]
`default_nettype none

module bmm_cfg (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [bmm_pkg::ApbAW-1:0] paddr,
	input  wire logic [bmm_pkg::ApbDW-1:0] pwdata,
	output logic      [bmm_pkg::ApbDW-1:0] prdata,
	output logic                           pready,
	output bmm_pkg::cfg_t                  cfg
);
	import bmm_pkg::*;

	logic             ram_128k_enable_q;
	logic [ApbDW-1:0] slots_q [4];
	logic             wr_en;
	logic [2:0]       idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[ApbAW-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_128k_enable_q <= 1'b1;
			for (int i = 0; i < 4; i++) begin
				slots_q[i] <= '0;
			end
		end else if (wr_en) begin
			unique case (idx)
				REG_RAM128:  ram_128k_enable_q <= pwdata[0];
				REG_SLOTS_A: slots_q[0] <= pwdata;
				REG_SLOTS_B: slots_q[1] <= pwdata;
				REG_SLOTS_C: slots_q[2] <= pwdata;
				REG_SLOTS_D: slots_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RAM128:  prdata = {{(ApbDW-1){1'b0}}, ram_128k_enable_q};
			REG_SLOTS_A: prdata = slots_q[0];
			REG_SLOTS_B: prdata = slots_q[1];
			REG_SLOTS_C: prdata = slots_q[2];
			REG_SLOTS_D: prdata = slots_q[3];
			default:     prdata = '0;
		endcase
	end

	assign cfg.ram_128k_enable = ram_128k_enable_q;
	assign cfg.slots_present   = {slots_q[3], slots_q[2], slots_q[1], slots_q[0]};

endmodule

`default_nettype wire

[rtl/bmm_xlate.sv]
`default_nettype none

module bmm_xlate (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  bmm_pkg::cfg_t        cfg,
	input  bmm_pkg::item_t       item,
	input  wire logic            step,
	output bmm_pkg::result_t     res
);
	import bmm_pkg::*;

	logic [2:0]       ram_config_q;
	logic [SlotW-1:0] upper_slot_q;
	logic [1:0]       area;
	logic [OffW-1:0]  offset;
	logic [BankW-1:0] bank;
	logic             cfg_hit;
	logic             slot_hit;
	logic             slot_ok;

	assign area   = item.bus_address[AddrW-1 -: 2];
	assign offset = item.bus_address[OffW-1:0];
	assign bank   = bank_of(ram_config_q, area);

	// port decode for io writes
	assign cfg_hit  = (item.action == ACT_IO_WR) && !item.bus_address[15]
		&& (item.bus_data[7:6] == RAMCFG_SEL) && cfg.ram_128k_enable;
	assign slot_hit = (item.action == ACT_IO_WR) && !item.bus_address[13];
	assign slot_ok  = (item.bus_data != '0) && cfg.slots_present[item.bus_data];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_config_q <= '0;
			upper_slot_q <= '0;
		end else if (step) begin
			if (cfg_hit) begin
				ram_config_q <= item.bus_data[2:0];
			end
			if (slot_hit) begin
				upper_slot_q <= slot_ok ? item.bus_data : '0;
			end
		end
	end

	always_comb begin
		res = '0;
		res.target = TGT_NONE;
		unique case (item.action)
			ACT_MEM_RD: begin
				if (area == AREA_LOW && item.lower_rom_on) begin
					res.target     = TGT_LROM;
					res.rom_offset = offset;
				end else if (area == AREA_HIGH && item.upper_rom_on) begin
					res.rom_offset = offset;
					if (upper_slot_q != '0) begin
						res.target   = TGT_EXP;
						res.exp_slot = upper_slot_q;
					end else begin
						res.target = TGT_IROM;
					end
				end else begin
					res.target       = TGT_RAM;
					res.ram_location = {bank, offset};
				end
			end
			ACT_MEM_WR: begin
				res.target       = TGT_RAM;
				res.ram_location = {bank, offset};
				res.write_strobe = 1'b1;
				res.write_byte   = item.bus_data;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

[tb/banked_memory_mapper_tb.sv]
`default_nettype none

module banked_memory_mapper_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import bmm_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int unsigned RandPerPhase = 236;
	localparam int unsigned NumPhases = 7;
	localparam int unsigned SettleCycles = 4;
	localparam int unsigned CycleLimit = 600000;
	localparam logic [63:0] ALL_ONES = '1;
	localparam logic [63:0] ALL_ZEROS = '0;

	// ram bank per config (rows) and 16k area (columns)
	localparam logic [2:0] BANK_MAP [8][4] = '{
		'{3'd0, 3'd1, 3'd2, 3'd3},
		'{3'd0, 3'd1, 3'd2, 3'd7},
		'{3'd4, 3'd5, 3'd6, 3'd7},
		'{3'd0, 3'd3, 3'd2, 3'd7},
		'{3'd0, 3'd4, 3'd2, 3'd3},
		'{3'd0, 3'd5, 3'd2, 3'd3},
		'{3'd0, 3'd6, 3'd2, 3'd3},
		'{3'd0, 3'd7, 3'd2, 3'd3}
	};

	class map_scoreboard;
		logic         ram128_en;
		logic [255:0] slot_present;
		logic [2:0]   ram_cfg;
		logic [7:0]   upper_slot;
		result_t      mapping_q[$];
		int           errors;

		function new();
			ram128_en = 1'b1;
			slot_present = '0;
			ram_cfg = '0;
			upper_slot = '0;
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [63:0] val);
			case (idx)
				REG_RAM128:  ram128_en = val[0];
				REG_SLOTS_A: slot_present[63:0] = val;
				REG_SLOTS_B: slot_present[127:64] = val;
				REG_SLOTS_C: slot_present[191:128] = val;
				REG_SLOTS_D: slot_present[255:192] = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return mapping_q.size();
		endfunction

		// translate one request and update the bank and slot selection
		function void note(item_t req);
			result_t    r;
			logic [1:0] area;
			logic [13:0] off;
			r = '0;
			area = req.bus_address[15:14];
			off = req.bus_address[13:0];
			case (req.action)
				ACT_MEM_RD: begin
					if (area == AREA_LOW && req.lower_rom_on) begin
						r.target = TGT_LROM;
						r.rom_offset = off;
					end else if (area == AREA_HIGH && req.upper_rom_on) begin
						r.rom_offset = off;
						if (upper_slot != 0) begin
							r.target = TGT_EXP;
							r.exp_slot = upper_slot;
						end else begin
							r.target = TGT_IROM;
						end
					end else begin
						r.target = TGT_RAM;
						r.ram_location = {BANK_MAP[ram_cfg][area], off};
					end
				end
				ACT_MEM_WR: begin
					r.target = TGT_RAM;
					r.ram_location = {BANK_MAP[ram_cfg][area], off};
					r.write_strobe = 1'b1;
					r.write_byte = req.bus_data;
				end
				ACT_IO_WR: begin
					if (!req.bus_address[15] && req.bus_data[7:6] == RAMCFG_SEL && ram128_en)
						ram_cfg = req.bus_data[2:0];
					if (!req.bus_address[13])
						upper_slot = (req.bus_data != 0 && slot_present[req.bus_data]) ?
							req.bus_data : '0;
				end
				default: ;
			endcase
			mapping_q.push_back(r);
		endfunction

		function void flag(string name, logic [16:0] want, logic [16:0] got);
			errors++;
			$display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
		endfunction

		function void check(result_t got);
			result_t want;
			if (mapping_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result: target %0d ram_location %0h", $time,
					got.target, got.ram_location);
				return;
			end
			want = mapping_q.pop_front();
			if (got.target !== want.target)
				flag("target", 17'(want.target), 17'(got.target));
			if (got.ram_location !== want.ram_location)
				flag("ram_location", want.ram_location, got.ram_location);
			if (got.rom_offset !== want.rom_offset)
				flag("rom_offset", 17'(want.rom_offset), 17'(got.rom_offset));
			if (got.exp_slot !== want.exp_slot)
				flag("exp_slot", 17'(want.exp_slot), 17'(got.exp_slot));
			if (got.write_strobe !== want.write_strobe)
				flag("write_strobe", 17'(want.write_strobe), 17'(got.write_strobe));
			if (got.write_byte !== want.write_byte)
				flag("write_byte", 17'(want.write_byte), 17'(got.write_byte));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b1;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ApbAW-1:0]  paddr = '0;
	logic [ApbDW-1:0]  pwdata = '0;
	logic [ApbDW-1:0]  prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        action = '0;
	logic [15:0]       bus_address = '0;
	logic [7:0]        bus_data = '0;
	logic              lower_rom_on = 1'b0;
	logic              upper_rom_on = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [2:0]        target;
	logic [16:0]       ram_location;
	logic [13:0]       rom_offset;
	logic [7:0]        exp_slot;
	logic              write_strobe;
	logic [7:0]        write_byte;

	map_scoreboard     sb;
	bit                calm = 1'b0;
	int unsigned       cycle_count = 0;

	banked_memory_mapper u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.bus_address  (bus_address),
		.bus_data     (bus_data),
		.lower_rom_on (lower_rom_on),
		.upper_rom_on (upper_rom_on),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.target       (target),
		.ram_location (ram_location),
		.rom_offset   (rom_offset),
		.exp_slot     (exp_slot),
		.write_strobe (write_strobe),
		.write_byte   (write_byte)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note(item_t'{action, bus_address, bus_data, lower_rom_on, upper_rom_on});
			if (out_valid && out_ready)
				sb.check(result_t'{target_t'(target), ram_location, rom_offset, exp_slot,
					write_strobe, write_byte});
		end
	end

	function automatic int idle_len();
		int k;
		if (calm)
			return 0;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 0;
		if (k < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// mostly well-formed bus cycles, biased toward mapping updates and rom overlays
	function automatic item_t rand_req();
		item_t r;
		int    k;
		r.action = ACT_MEM_RD;
		r.bus_address = 16'($urandom);
		r.bus_data = 8'($urandom);
		r.lower_rom_on = 1'($urandom);
		r.upper_rom_on = 1'($urandom);
		k = $urandom_range(0, 99);
		if (k < 35) begin
			r.action = ACT_MEM_RD;
		end else if (k < 55) begin
			r.action = ACT_MEM_WR;
		end else if (k < 90) begin
			r.action = ACT_IO_WR;
			if ($urandom_range(0, 2) != 0)
				r.bus_address[15] = 1'b0;
			if ($urandom_range(0, 2) != 0)
				r.bus_address[13] = 1'b0;
			if ($urandom_range(0, 1) != 0)
				r.bus_data[7:6] = RAMCFG_SEL;
		end else if (k < 95) begin
			r.action = ACT_UNUSED;
		end else begin
			r.action = ACT_MEM_RD;
			r.bus_address[15:14] = AREA_HIGH;
			r.upper_rom_on = 1'b1;
		end
		return r;
	endfunction

	initial begin
		int hold;
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			out_ready <= 1'b1;
			hold = $urandom_range(1, 20);
			repeat (hold - 1) @(posedge clk);
			gap = idle_len();
			if (gap > 0) begin
				@(posedge clk);
				out_ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end
		end
	end

	task automatic send_req(input item_t req);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= req.action;
		bus_address <= req.bus_address;
		bus_data <= req.bus_data;
		lower_rom_on <= req.lower_rom_on;
		upper_rom_on <= req.upper_rom_on;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_access(input logic [1:0] act, input logic [15:0] addr,
			input logic [7:0] data, input logic lo, input logic hi);
		send_req(item_t'{act, addr, data, lo, hi});
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ApbAW'({idx, 3'b000});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic load_cfg(input logic en, input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] c, input logic [63:0] d);
		write_reg(REG_RAM128, {63'd0, en});
		write_reg(REG_SLOTS_A, a);
		write_reg(REG_SLOTS_B, b);
		write_reg(REG_SLOTS_C, c);
		write_reg(REG_SLOTS_D, d);
	endtask

	task automatic phase_cfg(input int p);
		case (p)
			0: load_cfg(1'b1, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
			1: load_cfg(1'b0, ALL_ZEROS, ALL_ZEROS, ALL_ZEROS, ALL_ZEROS);
			2: load_cfg(1'b1, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom});
			3: load_cfg(1'b0, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
			4: load_cfg(1'b1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
				64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
			5: load_cfg(1'b1, {$urandom & $urandom, $urandom & $urandom},
				{$urandom & $urandom, $urandom & $urandom},
				{$urandom & $urandom, $urandom & $urandom},
				{$urandom & $urandom, $urandom & $urandom});
			default: load_cfg(1'b0, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom});
		endcase
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset mapping, no expansion slots present
		send_access(ACT_MEM_RD, 16'h0000, 8'h00, 1'b1, 1'b0);
		send_access(ACT_MEM_RD, 16'h3FFF, 8'hFF, 1'b0, 1'b1);
		send_access(ACT_MEM_RD, 16'hC000, 8'h00, 1'b0, 1'b1);
		send_access(ACT_MEM_RD, 16'hFFFF, 8'h00, 1'b1, 1'b0);
		send_access(ACT_MEM_WR, 16'hFFFF, 8'hFF, 1'b0, 1'b0);
		send_access(ACT_MEM_WR, 16'h0000, 8'h00, 1'b1, 1'b1);
		send_access(ACT_IO_WR, 16'h7F00, 8'hC7, 1'b0, 1'b0);
		send_access(ACT_MEM_RD, 16'h4000, 8'h00, 1'b1, 1'b1);
		send_access(ACT_IO_WR, 16'h7F00, 8'hC2, 1'b0, 1'b0);
		send_access(ACT_MEM_RD, 16'h8000, 8'h00, 1'b0, 1'b0);
		send_access(ACT_IO_WR, 16'h8000, 8'hC3, 1'b1, 1'b1);
		send_access(ACT_IO_WR, 16'h0000, 8'h05, 1'b0, 1'b0);
		send_access(ACT_UNUSED, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
		send_access(ACT_MEM_RD, 16'hC000, 8'h00, 1'b1, 1'b1);

		// 128k disabled, a few slots present
		settle();
		load_cfg(1'b0, 64'h21, 64'h8000_0000_0000_0001, 64'h1, 64'h8000_0000_0000_0000);
		send_access(ACT_IO_WR, 16'h7F00, 8'hC1, 1'b0, 1'b0);
		send_access(ACT_MEM_RD, 16'hC000, 8'h00, 1'b0, 1'b1);
		send_access(ACT_IO_WR, 16'hDFFF, 8'h05, 1'b0, 1'b0);
		send_access(ACT_MEM_RD, 16'hFFFF, 8'h00, 1'b0, 1'b1);
		send_access(ACT_IO_WR, 16'h1FFF, 8'hFF, 1'b0, 1'b0);
		send_access(ACT_MEM_RD, 16'hC123, 8'h00, 1'b1, 1'b1);

		// presence dropped after selection keeps the latched slot
		settle();
		load_cfg(1'b1, ALL_ZEROS, ALL_ZEROS, ALL_ZEROS, 64'h8);
		send_access(ACT_MEM_RD, 16'hC000, 8'h00, 1'b0, 1'b1);
		send_access(ACT_IO_WR, 16'h0000, 8'h00, 1'b0, 1'b0);
		send_access(ACT_IO_WR, 16'h0000, 8'hC3, 1'b0, 1'b0);
		send_access(ACT_MEM_RD, 16'hE000, 8'h00, 1'b0, 1'b1);
		send_access(ACT_MEM_RD, 16'h4000, 8'h00, 1'b0, 1'b0);

		for (int p = 0; p < NumPhases; p++) begin
			settle();
			phase_cfg(p);
			calm = (p % 3 == 2);
			repeat (RandPerPhase) send_req(rand_req());
		end

		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/bmm_pkg.sv
rtl/bmm_cfg.sv
rtl/bmm_xlate.sv
rtl/banked_memory_mapper.sv
tb/banked_memory_mapper_tb.sv
